// File: hw/rtl/stl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and constants for the source text lexer: token kinds,
// token and bundle structures, character constants.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int MAX_TOKENS  = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int LEN_W       = 16;
    localparam int POS_W       = 16;

    // token kind codes as seen on the output
    typedef enum logic [4:0] {
        KIND_ARITH    = 5'd0,
        KIND_COMPARE  = 5'd1,
        KIND_EQUALS   = 5'd2,
        KIND_LOGIC    = 5'd3,
        KIND_LPAREN   = 5'd4,
        KIND_RPAREN   = 5'd5,
        KIND_LBRACE   = 5'd6,
        KIND_RBRACE   = 5'd7,
        KIND_LBRACKET = 5'd8,
        KIND_RBRACKET = 5'd9,
        KIND_COMMA    = 5'd10,
        KIND_COLON    = 5'd11,
        KIND_ENDLINE  = 5'd12,
        KIND_NUMBER   = 5'd13,
        KIND_IDENT    = 5'd14,
        KIND_FOR      = 5'd15,
        KIND_IF       = 5'd16,
        KIND_WAVE     = 5'd17,
        KIND_FUNC     = 5'd18,
        KIND_RETURN   = 5'd19,
        KIND_EOF      = 5'd20,
        KIND_ERROR    = 5'd21
    } token_kind_t;

    // character constants
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_EOF_MARK   = 8'h45;

    // one token as produced by the front end
    typedef struct packed {
        token_kind_t        kind;
        logic [7:0]         first_char;
        logic               second_is_equals;
        logic [LEN_W-1:0]   text_length;
        logic [POS_W-1:0]   start_line;
        logic [POS_W-1:0]   start_column;
    } stl_token_t;

    // all tokens caused by one accepted character
    typedef struct packed {
        logic [2:0]                    count;
        stl_token_t [MAX_TOKENS-1:0]   tok;
    } stl_bundle_t;

endpackage

// File: hw/rtl/stl_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_char_if / stl_token_if
// Valid/ready channels of the lexer: source characters in, tokens out.
// ----------------------------------------------------------------------------
interface stl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       carries_char;
    logic       end_of_source;

    modport source (output valid, output char_code, output carries_char,
                    output end_of_source, input ready);
    modport sink   (input valid, input char_code, input carries_char,
                    input end_of_source, output ready);
endinterface

interface stl_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [7:0]  first_char;
    logic        second_is_equals;
    logic [15:0] text_length;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic        last_of_run;

    modport source (output valid, output token_kind, output first_char,
                    output second_is_equals, output text_length,
                    output start_line, output start_column,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input first_char,
                    input second_is_equals, input text_length,
                    input start_line, input start_column,
                    input last_of_run, output ready);
endinterface

// File: hw/rtl/stl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_front
// Lexer front end: takes one character a cycle while there is space, updates
// the scanner state and builds the bundle of tokens that the character completes.
// ----------------------------------------------------------------------------
module stl_front
    import stl_pkg::*;
#(
    parameter int POSITION_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    stl_char_if.sink    chars,
    input  logic        space,
    output logic        push,
    output stl_bundle_t bundle
);

    localparam logic [POS_W-1:0] POS_MAX = (POSITION_WIDTH >= POS_W) ?
        {POS_W{1'b1}} : POS_W'((64'd1 << POSITION_WIDTH) - 64'd1);
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_CMP   = 2'd1,
        PEND_NUM   = 2'd2,
        PEND_IDENT = 2'd3
    } pend_class_t;

    pend_class_t      pclass_reg, pclass_next;
    logic [7:0]       pchar_reg,  pchar_next;
    logic [POS_W-1:0] tline_reg,  tline_next;
    logic [POS_W-1:0] tcol_reg,   tcol_next;
    logic [POS_W-1:0] line_reg,   line_next;
    logic [POS_W-1:0] col_reg,    col_next;
    logic [LEN_W-1:0] plen_reg,   plen_next;
    logic [1:0]       dots_reg,   dots_next;
    logic [47:0]      win_reg,    win_next;
    logic             halted_reg, halted_next;

    logic             fire;
    logic [2:0]       cnt;
    stl_bundle_t      bnd;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] v);
        return (v < POS_MAX) ? v + POS_W'(1) : POS_MAX;
    endfunction

    function automatic stl_token_t make_tok(input token_kind_t k, input logic [7:0] fc,
                                            input logic eq, input logic [LEN_W-1:0] len,
                                            input logic [POS_W-1:0] ln,
                                            input logic [POS_W-1:0] cl);
        stl_token_t t;
        t.kind             = k;
        t.first_char       = fc;
        t.second_is_equals = eq;
        t.text_length      = len;
        t.start_line       = ln;
        t.start_column     = cl;
        return t;
    endfunction

    // identifier or keyword from the last six characters
    function automatic token_kind_t word_kind(input logic [47:0] w,
                                              input logic [LEN_W-1:0] len);
        token_kind_t k;
        k = KIND_IDENT;
        if (len == LEN_W'(3) && w[23:0] == "for")
            k = KIND_FOR;
        else if (len == LEN_W'(2) && w[15:0] == "if")
            k = KIND_IF;
        else if (len == LEN_W'(4) && w[31:0] == "Wave")
            k = KIND_WAVE;
        else if (len == LEN_W'(4) && w[31:0] == "func")
            k = KIND_FUNC;
        else if (len == LEN_W'(6) && w[47:0] == "return")
            k = KIND_RETURN;
        return k;
    endfunction

    // pending token as it is emitted on a flush
    function automatic stl_token_t pend_tok(input pend_class_t pc, input logic [7:0] fc,
                                            input logic [LEN_W-1:0] len,
                                            input logic [47:0] w,
                                            input logic [POS_W-1:0] ln,
                                            input logic [POS_W-1:0] cl);
        token_kind_t k;
        logic [LEN_W-1:0] l;
        k = KIND_NUMBER;
        l = len;
        if (pc == PEND_CMP) begin
            k = (fc == CH_EQUALS) ? KIND_EQUALS : ((fc == "!") ? KIND_LOGIC : KIND_COMPARE);
            l = LEN_W'(1);
        end
        else if (pc == PEND_IDENT) begin
            k = word_kind(w, len);
        end
        return make_tok(k, fc, 1'b0, l, ln, cl);
    endfunction

    assign fire        = chars.valid && space;
    assign chars.ready = space;
    assign push        = fire && (bnd.count != 3'd0);
    assign bundle      = bnd;

    // next scanner state and token bundle for the character at the input
    always_comb
    begin
        logic [7:0]  c;
        logic        done;
        logic        err;
        token_kind_t single_kind;
        logic        single;

        pclass_next = pclass_reg;
        pchar_next  = pchar_reg;
        tline_next  = tline_reg;
        tcol_next   = tcol_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        plen_next   = plen_reg;
        dots_next   = dots_reg;
        win_next    = win_reg;
        halted_next = halted_reg;
        bnd         = '0;
        cnt         = 3'd0;
        c           = chars.char_code;
        done        = 1'b0;
        err         = 1'b0;
        single_kind = KIND_ARITH;
        single      = 1'b0;

        if (!halted_reg) begin
            if (chars.carries_char) begin
                // continue the pending token if the character fits
                unique case (pclass_next)
                    PEND_CMP:
                    begin
                        if (c == CH_EQUALS) begin
                            bnd.tok[cnt[1:0]] = make_tok(KIND_COMPARE, pchar_next, 1'b1,
                                                         LEN_W'(2), tline_next, tcol_next);
                            cnt         = cnt + 3'd1;
                            pclass_next = PEND_NONE;
                            plen_next   = '0;
                            col_next    = pos_inc(col_next);
                            done        = 1'b1;
                        end
                    end
                    PEND_NUM:
                    begin
                        if (is_digit(c) || c == CH_DOT) begin
                            if (c == CH_DOT)
                                dots_next = (dots_next < 2'd2) ? dots_next + 2'd1 : 2'd2;
                            plen_next = (plen_next < LEN_MAX) ? plen_next + LEN_W'(1)
                                                              : LEN_MAX;
                            win_next  = {win_next[39:0], c};
                            col_next  = pos_inc(col_next);
                            done      = 1'b1;
                            if (dots_next > 2'd1) begin
                                bnd.tok[cnt[1:0]] = make_tok(KIND_ERROR, pchar_next, 1'b0,
                                                             plen_next, tline_next,
                                                             tcol_next);
                                cnt         = cnt + 3'd1;
                                halted_next = 1'b1;
                                err         = 1'b1;
                            end
                        end
                    end
                    PEND_IDENT:
                    begin
                        if (is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE) begin
                            plen_next = (plen_next < LEN_MAX) ? plen_next + LEN_W'(1)
                                                              : LEN_MAX;
                            win_next  = {win_next[39:0], c};
                            col_next  = pos_inc(col_next);
                            done      = 1'b1;
                        end
                    end
                    PEND_NONE:
                    begin
                        done = 1'b0;
                    end
                    default:
                    begin
                        done = 1'b0;
                    end
                endcase

                // flush a pending token that the character ends
                if (!done && pclass_next != PEND_NONE) begin
                    bnd.tok[cnt[1:0]] = pend_tok(pclass_next, pchar_next, plen_next,
                                                 win_next, tline_next, tcol_next);
                    cnt         = cnt + 3'd1;
                    pclass_next = PEND_NONE;
                    plen_next   = '0;
                    dots_next   = '0;
                    win_next    = '0;
                end

                // character that starts something new
                if (!done) begin
                    tline_next = line_next;
                    tcol_next  = col_next;
                    unique case (c)
                        "+", "-", "*", "/", "%", "^":
                        begin
                            single      = 1'b1;
                            single_kind = KIND_ARITH;
                        end
                        "&", "|":
                        begin
                            single      = 1'b1;
                            single_kind = KIND_LOGIC;
                        end
                        "(":
                        begin
                            single      = 1'b1;
                            single_kind = KIND_LPAREN;
                        end
                        ")":
                        begin
                            single      = 1'b1;
                            single_kind = KIND_RPAREN;
                        end
                        "{":
                        begin
                            single      = 1'b1;
                            single_kind = KIND_LBRACE;
                        end
                        "}":
                        begin
                            single      = 1'b1;
                            single_kind = KIND_RBRACE;
                        end
                        "[":
                        begin
                            single      = 1'b1;
                            single_kind = KIND_LBRACKET;
                        end
                        "]":
                        begin
                            single      = 1'b1;
                            single_kind = KIND_RBRACKET;
                        end
                        ",":
                        begin
                            single      = 1'b1;
                            single_kind = KIND_COMMA;
                        end
                        ":":
                        begin
                            single      = 1'b1;
                            single_kind = KIND_COLON;
                        end
                        "<", ">", "=", "!":
                        begin
                            pclass_next = PEND_CMP;
                            pchar_next  = c;
                            plen_next   = LEN_W'(1);
                            dots_next   = '0;
                            win_next    = {40'd0, c};
                        end
                        CH_NEWLINE:
                        begin
                            single      = 1'b1;
                            single_kind = KIND_ENDLINE;
                        end
                        default:
                        begin
                            if (is_digit(c) || c == CH_DOT) begin
                                pclass_next = PEND_NUM;
                                pchar_next  = c;
                                plen_next   = LEN_W'(1);
                                dots_next   = (c == CH_DOT) ? 2'd1 : 2'd0;
                                win_next    = {40'd0, c};
                            end
                            else if (is_alpha(c)) begin
                                pclass_next = PEND_IDENT;
                                pchar_next  = c;
                                plen_next   = LEN_W'(1);
                                dots_next   = '0;
                                win_next    = {40'd0, c};
                            end
                        end
                    endcase
                    if (single) begin
                        bnd.tok[cnt[1:0]] = make_tok(single_kind, c, 1'b0, LEN_W'(1),
                                                     line_next, col_next);
                        cnt = cnt + 3'd1;
                    end
                    // newline moves to the next line, anything else one column
                    if (c == CH_NEWLINE) begin
                        line_next = pos_inc(line_next);
                        col_next  = POS_W'(1);
                    end
                    else begin
                        col_next = pos_inc(col_next);
                    end
                end
            end

            // end of source: flush, endline, end of file, then start over
            if (chars.end_of_source && !err) begin
                if (pclass_next != PEND_NONE) begin
                    bnd.tok[cnt[1:0]] = pend_tok(pclass_next, pchar_next, plen_next,
                                                 win_next, tline_next, tcol_next);
                    cnt = cnt + 3'd1;
                end
                bnd.tok[cnt[1:0]] = make_tok(KIND_ENDLINE, CH_NEWLINE, 1'b0, LEN_W'(1),
                                             line_next, col_next);
                cnt = cnt + 3'd1;
                bnd.tok[cnt[1:0]] = make_tok(KIND_EOF, CH_EOF_MARK, 1'b0, LEN_W'(3),
                                             line_next, col_next);
                cnt = cnt + 3'd1;
                pclass_next = PEND_NONE;
                pchar_next  = '0;
                tline_next  = POS_W'(1);
                tcol_next   = POS_W'(1);
                line_next   = POS_W'(1);
                col_next    = POS_W'(1);
                plen_next   = '0;
                dots_next   = '0;
                win_next    = '0;
            end
        end
        bnd.count = cnt;
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pclass_reg <= PEND_NONE;
            pchar_reg  <= '0;
            tline_reg  <= POS_W'(1);
            tcol_reg   <= POS_W'(1);
            line_reg   <= POS_W'(1);
            col_reg    <= POS_W'(1);
            plen_reg   <= '0;
            dots_reg   <= '0;
            win_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else if (fire) begin
            pclass_reg <= pclass_next;
            pchar_reg  <= pchar_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            plen_reg   <= plen_next;
            dots_reg   <= dots_next;
            win_reg    <= win_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// File: hw/rtl/stl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_queue
// Short queue of token bundles between the front and back ends.
// ----------------------------------------------------------------------------
module stl_queue
    import stl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  stl_bundle_t wr_bundle,
    input  logic        pop,
    output stl_bundle_t head,
    output logic        not_empty,
    output logic        not_full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    stl_bundle_t      mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg,   fill_next;
    logic             do_push;
    logic             do_pop;

    assign not_empty = (fill_reg != '0);
    assign not_full  = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign head      = mem[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = do_push ? ((wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                          : wr_ptr_reg + PTR_W'(1))
                              : wr_ptr_reg;
        rd_ptr_next = do_pop ? ((rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                         : rd_ptr_reg + PTR_W'(1))
                             : rd_ptr_reg;
        fill_next   = fill_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // bundle storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_bundle;
    end

endmodule

// File: hw/rtl/stl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_back
// Lexer back end: walks the head bundle one token a cycle unless the output
// stalls, into the registered output stage; marks the last token of each character.
// ----------------------------------------------------------------------------
module stl_back
    import stl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  stl_bundle_t head,
    input  logic        avail,
    output logic        pop,
    stl_token_if.source tokens
);

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    stl_token_t  tok_reg;
    logic        last_reg;
    logic        load;
    logic        at_last;

    assign load    = avail && (!valid_reg || tokens.ready);
    assign at_last = ({1'b0, idx_reg} == (head.count - 3'd1));
    assign pop     = load && at_last;

    // slot index and output valid
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (tokens.ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            tok_reg  <= head.tok[idx_reg];
            last_reg <= at_last;
        end
    end

    assign tokens.valid            = valid_reg;
    assign tokens.token_kind       = tok_reg.kind;
    assign tokens.first_char       = tok_reg.first_char;
    assign tokens.second_is_equals = tok_reg.second_is_equals;
    assign tokens.text_length      = tok_reg.text_length;
    assign tokens.start_line       = tok_reg.start_line;
    assign tokens.start_column     = tok_reg.start_column;
    assign tokens.last_of_run      = last_reg;

endmodule

// File: hw/rtl/source_text_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_lexer
// Streaming tokenizer: source characters in, tokens with kind, first
// character, length and start position out.
//
//   channel   dir   carries
//   chars     in    char_code, carries_char, end_of_source
//   tokens    out   token_kind, first_char, second_is_equals, text_length,
//                   start_line, start_column, last_of_run
//
// One character is accepted per cycle while the queue is not full; the front
// end finishes its work in that cycle and queues up to four tokens as one
// bundle. The back end sends one token per cycle while the output is not
// stalled; the four-bundle queue sets how long input keeps flowing while the
// output is slower or stalled. The first token is registered in the bundle
// queue and then in the output stage before it is valid.
// Reset is asynchronous and immediate: positions return to line 1, column 1.
// ----------------------------------------------------------------------------
module source_text_lexer
    import stl_pkg::*;
#(
    parameter int POSITION_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    stl_char_if.sink    chars,
    stl_token_if.source tokens
);

    stl_bundle_t wr_bundle;
    stl_bundle_t head;
    logic        push;
    logic        pop;
    logic        not_empty;
    logic        not_full;

    // character scanning
    stl_front #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .space  (not_full),
        .push   (push),
        .bundle (wr_bundle)
    );

    // bundle queue
    stl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_bundle (wr_bundle),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .not_full  (not_full)
    );

    // token output
    stl_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .avail  (not_empty),
        .pop    (pop),
        .tokens (tokens)
    );

endmodule

// File: hw/rtl/stl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_checker
// Port-level checks on the lexer token output, bound to the top level.
// ----------------------------------------------------------------------------
module stl_checker
    import stl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        tok_valid,
    input logic        tok_ready,
    input logic [4:0]  tok_kind,
    input logic [7:0]  tok_first_char,
    input logic [15:0] tok_length,
    input logic [15:0] tok_line,
    input logic [15:0] tok_column,
    input logic        tok_last
);

    // a token waiting on the output is not withdrawn
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid)
    else $error("token withdrawn while stalled");

    // kind stays within the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> tok_kind <= KIND_ERROR)
    else $error("undefined token kind");

    // positions count from one
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> (tok_line != 16'd0) && (tok_column != 16'd0))
    else $error("token position zero");

    // end of file is the last token of its run and has fixed text
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_kind == KIND_EOF |->
            tok_last && tok_length == 16'd3 && tok_first_char == CH_EOF_MARK)
    else $error("malformed end of file token");

    // endline tokens are one newline long
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_kind == KIND_ENDLINE |->
            tok_length == 16'd1 && tok_first_char == CH_NEWLINE)
    else $error("malformed endline token");

endmodule

bind source_text_lexer stl_checker u_stl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .tok_valid      (tokens.valid),
    .tok_ready      (tokens.ready),
    .tok_kind       (tokens.token_kind),
    .tok_first_char (tokens.first_char),
    .tok_length     (tokens.text_length),
    .tok_line       (tokens.start_line),
    .tok_column     (tokens.start_column),
    .tok_last       (tokens.last_of_run)
);
